### src/sts_pkg.sv
package sts_pkg;

   localparam int WORD_W = 32;
   localparam int CMD_W  = 2;
   localparam int POS_W  = 4;
   localparam int IDX_W  = 4;

   typedef enum logic [CMD_W-1:0] {
      CMD_LOAD = 2'd0,
      CMD_SORT = 2'd1,
      CMD_SEQ  = 2'd2,
      CMD_BIN  = 2'd3
   } cmd_type;

   // Program steps. Steps that fall through rely on this order.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SO_READ_I,
      ST_SO_FIRST,
      ST_SO_SCAN,
      ST_SO_SWAP_LO,
      ST_SO_SWAP_I,
      ST_SO_NEXT,
      ST_SO_DONE,
      ST_SQ_PRIME,
      ST_SQ_SCAN,
      ST_MISS,
      ST_HIT,
      ST_BS_PROBE,
      ST_BS_CHECK
   } step_type;

   typedef enum logic [1:0] {RD_I, RD_J, RD_MID} rd_sel_type;
   typedef enum logic [1:0] {WR_NONE, WR_LO_VI, WR_I_MIN} wr_op_type;
   typedef enum logic [1:0] {I_KEEP, I_INC, I_BIN} i_op_type;
   typedef enum logic [2:0] {J_KEEP, J_I_INC, J_INC, J_DEC, J_BIN} j_op_type;
   typedef enum logic [1:0] {M_KEEP, M_LOAD, M_CMP, M_MARK} m_op_type;
   typedef enum logic [1:0] {RES_NONE, RES_SORT, RES_HIT, RES_MISS} res_op_type;
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_EQ,
      C_ADDR_NZ,
      C_ADDR_LAST,
      C_I_LAST,
      C_LO_GT_HI
   } cond_type;

   typedef struct packed {
      logic       rd_en;
      rd_sel_type rd_sel;
      wr_op_type  wr_op;
      i_op_type   i_op;
      j_op_type   j_op;
      m_op_type   m_op;
      res_op_type res_op;
      cond_type   cond_a;
      step_type   tgt_a;
      cond_type   cond_b;
      step_type   tgt_b;
   } ctl_word_type;

   typedef struct packed {
      logic eq;
      logic addr_nz;
      logic addr_last;
      logic i_last;
      logic lo_gt_hi;
   } flags_type;

   localparam ctl_word_type UC_NOP = '{
      rd_en:  1'b0,
      rd_sel: RD_I,
      wr_op:  WR_NONE,
      i_op:   I_KEEP,
      j_op:   J_KEEP,
      m_op:   M_KEEP,
      res_op: RES_NONE,
      cond_a: C_NEVER,
      tgt_a:  ST_IDLE,
      cond_b: C_NEVER,
      tgt_b:  ST_IDLE
   };

   // Microcode ROM. The first jump is tried first, then the second,
   // otherwise the program falls through to the next step.
   function automatic ctl_word_type ucode(input step_type step);
      ctl_word_type w;
      w = UC_NOP;
      unique case (step)
         ST_IDLE: begin
         end
         ST_SO_READ_I: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_I;
            w.j_op   = J_I_INC;
            w.cond_a = C_I_LAST;
            w.tgt_a  = ST_SO_DONE;
         end
         ST_SO_FIRST: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_J;
            w.j_op   = J_INC;
            w.m_op   = M_LOAD;
         end
         ST_SO_SCAN: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_J;
            w.j_op   = J_INC;
            w.m_op   = M_CMP;
            w.cond_a = C_ADDR_LAST;
            w.tgt_a  = ST_SO_SWAP_LO;
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_SO_SCAN;
         end
         ST_SO_SWAP_LO: begin
            w.wr_op = WR_LO_VI;
         end
         ST_SO_SWAP_I: begin
            w.wr_op = WR_I_MIN;
         end
         ST_SO_NEXT: begin
            w.i_op   = I_INC;
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_SO_READ_I;
         end
         ST_SO_DONE: begin
            w.res_op = RES_SORT;
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_IDLE;
         end
         ST_SQ_PRIME: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_J;
            w.j_op   = J_DEC;
         end
         ST_SQ_SCAN: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_J;
            w.j_op   = J_DEC;
            w.m_op   = M_MARK;
            w.cond_a = C_EQ;
            w.tgt_a  = ST_HIT;
            w.cond_b = C_ADDR_NZ;
            w.tgt_b  = ST_SQ_SCAN;
         end
         ST_MISS: begin
            w.res_op = RES_MISS;
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_IDLE;
         end
         ST_HIT: begin
            w.res_op = RES_HIT;
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_IDLE;
         end
         ST_BS_PROBE: begin
            w.rd_en  = 1'b1;
            w.rd_sel = RD_MID;
            w.cond_a = C_LO_GT_HI;
            w.tgt_a  = ST_MISS;
         end
         ST_BS_CHECK: begin
            w.i_op   = I_BIN;
            w.j_op   = J_BIN;
            w.m_op   = M_MARK;
            w.cond_a = C_EQ;
            w.tgt_a  = ST_HIT;
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_BS_PROBE;
         end
         default: begin
            w.cond_b = C_ALWAYS;
            w.tgt_b  = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

### src/sorted_table_search_engine.sv
// A load is written in its accept cycle and gives no result; a sequential search, a binary
// search and a sort each post one result through the output register.
// Throughput: one command at a time; the single read port of the table, one read a
// cycle, paces the microcode. Loads can be taken every cycle while the engine is idle.
// Reset: sequencer to idle and result register empty; table contents are kept.
module sorted_table_search_engine #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [sts_pkg::CMD_W-1:0]           req_cmd,
   input  logic [sts_pkg::POS_W-1:0]           req_position,
   input  logic signed [sts_pkg::WORD_W-1:0]   req_value,
   input  logic signed [sts_pkg::WORD_W-1:0]   req_key,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_found,
   output logic [sts_pkg::IDX_W-1:0]           rsp_match_index
);

   localparam int IW = $clog2(ENTRIES);

   sts_pkg::ctl_word_type ctl;
   sts_pkg::flags_type    flags;
   logic                  start;
   logic                  run;
   logic                  emit;
   logic                  out_busy;
   logic                  ld_en;
   logic [IW-1:0]         hit_index;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       found_ff, found_in;
   logic [sts_pkg::IDX_W-1:0]  idx_ff, idx_in;

   assign start    = req_valid && req_ready;
   assign ld_en    = start && (req_cmd == sts_pkg::CMD_LOAD) &&
                     (32'(req_position) < 32'(ENTRIES));
   assign out_busy = rsp_valid_ff && !rsp_ready;
   assign emit     = run && (ctl.res_op != sts_pkg::RES_NONE);

   sts_seq u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .cmd      (sts_pkg::cmd_type'(req_cmd)),
      .flags    (flags),
      .out_busy (out_busy),
      .ready    (req_ready),
      .run      (run),
      .ctl      (ctl)
   );

   sts_dp #(
      .ENTRIES (ENTRIES)
   ) u_dp (
      .clock     (clock),
      .start     (start),
      .key       (req_key),
      .ld_en     (ld_en),
      .ld_addr   (IW'(req_position)),
      .ld_data   (req_value),
      .run       (run),
      .ctl       (ctl),
      .flags     (flags),
      .hit_index (hit_index)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (emit) begin
         rsp_valid_in = 1'b1;
         unique case (ctl.res_op)
            sts_pkg::RES_HIT: begin
               found_in = 1'b1;
               idx_in   = sts_pkg::IDX_W'(hit_index);
            end
            default: begin
               found_in = 1'b0;
               idx_in   = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      found_ff <= found_in;
      idx_ff   <= idx_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_found       = found_ff;
   assign rsp_match_index = idx_ff;

endmodule

### src/sts_seq.sv
module sts_seq (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  sts_pkg::cmd_type        cmd,
   input  sts_pkg::flags_type      flags,
   input  logic                    out_busy,
   output logic                    ready,
   output logic                    run,
   output sts_pkg::ctl_word_type   ctl
);

   sts_pkg::step_type step_ff;
   sts_pkg::step_type step_in;
   logic              stall;

   function automatic logic cond_ok(input sts_pkg::cond_type c,
                                    input sts_pkg::flags_type f);
      logic r;
      unique case (c)
         sts_pkg::C_NEVER:     r = 1'b0;
         sts_pkg::C_ALWAYS:    r = 1'b1;
         sts_pkg::C_EQ:        r = f.eq;
         sts_pkg::C_ADDR_NZ:   r = f.addr_nz;
         sts_pkg::C_ADDR_LAST: r = f.addr_last;
         sts_pkg::C_I_LAST:    r = f.i_last;
         sts_pkg::C_LO_GT_HI:  r = f.lo_gt_hi;
         default:              r = 1'b0;
      endcase
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= sts_pkg::ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

   always_comb begin
      ctl     = sts_pkg::ucode(step_ff);
      ready   = (step_ff == sts_pkg::ST_IDLE);
      // A step that posts a result waits while the output register is full.
      stall   = (ctl.res_op != sts_pkg::RES_NONE) && out_busy;
      run     = !ready && !stall;
      step_in = step_ff;
      if (ready) begin
         if (start) begin
            unique case (cmd)
               sts_pkg::CMD_LOAD: step_in = sts_pkg::ST_IDLE;
               sts_pkg::CMD_SORT: step_in = sts_pkg::ST_SO_READ_I;
               sts_pkg::CMD_SEQ:  step_in = sts_pkg::ST_SQ_PRIME;
               sts_pkg::CMD_BIN:  step_in = sts_pkg::ST_BS_PROBE;
               default:           step_in = sts_pkg::ST_IDLE;
            endcase
         end
      end else if (!stall) begin
         priority if (cond_ok(ctl.cond_a, flags)) begin
            step_in = ctl.tgt_a;
         end else if (cond_ok(ctl.cond_b, flags)) begin
            step_in = ctl.tgt_b;
         end else begin
            step_in = sts_pkg::step_type'(step_ff + 4'd1);
         end
      end
   end

endmodule

### src/sts_dp.sv
module sts_dp #(
   parameter int ENTRIES = 16
) (
   input  logic                                clock,
   input  logic                                start,
   input  logic signed [sts_pkg::WORD_W-1:0]   key,
   input  logic                                ld_en,
   input  logic [$clog2(ENTRIES)-1:0]          ld_addr,
   input  logic signed [sts_pkg::WORD_W-1:0]   ld_data,
   input  logic                                run,
   input  sts_pkg::ctl_word_type               ctl,
   output sts_pkg::flags_type                  flags,
   output logic [$clog2(ENTRIES)-1:0]          hit_index
);

   localparam int IW = $clog2(ENTRIES);
   localparam int CW = IW + 2;
   localparam logic signed [CW-1:0] LAST_C   = CW'(ENTRIES - 1);
   localparam logic [IW-1:0]        LAST_A   = IW'(ENTRIES - 1);

   logic signed [sts_pkg::WORD_W-1:0] mem [ENTRIES];

   logic signed [CW-1:0]              i_ff, i_in;
   logic signed [CW-1:0]              j_ff, j_in;
   logic [IW-1:0]                     lo_ff, lo_in;
   logic signed [sts_pkg::WORD_W-1:0] min_ff, min_in;
   logic signed [sts_pkg::WORD_W-1:0] vi_ff, vi_in;
   logic signed [sts_pkg::WORD_W-1:0] key_ff, key_in;
   logic signed [sts_pkg::WORD_W-1:0] rdata_ff;
   logic [IW-1:0]                     rd_addr_ff;

   logic [IW-1:0]                     rd_addr;
   logic                              rd_en;
   logic [CW-1:0]                     mid_sum;
   logic signed [CW-1:0]              addr_ext;
   logic                              gt;
   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic signed [sts_pkg::WORD_W-1:0] wr_data;

   always_comb begin
      mid_sum  = i_ff + j_ff;
      addr_ext = $signed(CW'(rd_addr_ff));
      gt       = rdata_ff > key_ff;

      unique case (ctl.rd_sel)
         sts_pkg::RD_I:   rd_addr = i_ff[IW-1:0];
         sts_pkg::RD_J:   rd_addr = j_ff[IW-1:0];
         sts_pkg::RD_MID: rd_addr = mid_sum[IW:1];
         default:         rd_addr = i_ff[IW-1:0];
      endcase
      rd_en = run && ctl.rd_en;

      wr_en   = 1'b0;
      wr_addr = ld_addr;
      wr_data = ld_data;
      if (ld_en) begin
         wr_en = 1'b1;
      end else if (run) begin
         unique case (ctl.wr_op)
            sts_pkg::WR_LO_VI: begin
               wr_en   = 1'b1;
               wr_addr = lo_ff;
               wr_data = vi_ff;
            end
            sts_pkg::WR_I_MIN: begin
               wr_en   = 1'b1;
               wr_addr = i_ff[IW-1:0];
               wr_data = min_ff;
            end
            default: wr_en = 1'b0;
         endcase
      end

      i_in   = i_ff;
      j_in   = j_ff;
      lo_in  = lo_ff;
      min_in = min_ff;
      vi_in  = vi_ff;
      key_in = key_ff;
      if (start) begin
         i_in   = '0;
         j_in   = LAST_C;
         key_in = key;
      end else if (run) begin
         unique case (ctl.i_op)
            sts_pkg::I_INC: i_in = i_ff + CW'(1);
            sts_pkg::I_BIN: if (!gt) i_in = addr_ext + CW'(1);
            default:        i_in = i_ff;
         endcase
         unique case (ctl.j_op)
            sts_pkg::J_I_INC: j_in = i_ff + CW'(1);
            sts_pkg::J_INC:   j_in = j_ff + CW'(1);
            sts_pkg::J_DEC:   j_in = j_ff - CW'(1);
            sts_pkg::J_BIN:   if (gt) j_in = addr_ext - CW'(1);
            default:          j_in = j_ff;
         endcase
         unique case (ctl.m_op)
            sts_pkg::M_LOAD: begin
               vi_in  = rdata_ff;
               min_in = rdata_ff;
               lo_in  = rd_addr_ff;
            end
            sts_pkg::M_CMP: begin
               // Strict compare keeps the first smallest entry.
               if (min_ff > rdata_ff) begin
                  min_in = rdata_ff;
                  lo_in  = rd_addr_ff;
               end
            end
            sts_pkg::M_MARK: lo_in = rd_addr_ff;
            default: lo_in = lo_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff   <= mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      i_ff   <= i_in;
      j_ff   <= j_in;
      lo_ff  <= lo_in;
      min_ff <= min_in;
      vi_ff  <= vi_in;
      key_ff <= key_in;
   end

   assign flags.eq        = (rdata_ff == key_ff);
   assign flags.addr_nz   = (rd_addr_ff != '0);
   assign flags.addr_last = (rd_addr_ff == LAST_A);
   assign flags.i_last    = (i_ff >= LAST_C);
   assign flags.lo_gt_hi  = (i_ff > j_ff);
   assign hit_index       = lo_ff;

endmodule

### src/sts_check.sv
module sts_check (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic [sts_pkg::CMD_W-1:0]           req_cmd,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic                                rsp_found,
   input logic [sts_pkg::IDX_W-1:0]           rsp_match_index
);

   // Coming out of reset the block is idle with no result pending.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (req_ready && !rsp_valid))
      else $error("block not idle after reset");

   // A sort or search keeps the input side closed on the following cycle.
   a_busy_after_cmd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_cmd != sts_pkg::CMD_LOAD)) |=> !req_ready)
      else $error("input accepted while a command is running");

   // A miss or a sort completion never carries an index.
   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_match_index == '0))
      else $error("index reported without a match");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_match_index)))
      else $error("stalled result transaction changed");

endmodule

bind sorted_table_search_engine sts_check u_sts_check (.*);
